>>> hdl/svce_pkg.sv
package svce_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int COUNT_BITS_DEF  = 32;

    // Widths of the stream fields
    localparam int MODE_W      = 3;
    localparam int KEY_PORT_W  = 32;
    localparam int CNT_PORT_W  = 32;
    localparam int S_TDATA_W   = 64;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 72;
    localparam int M_TUSER_W   = 3;

    typedef enum logic [2:0] {
        MODE_INC   = 3'd0,
        MODE_LOAD  = 3'd1,
        MODE_CMP   = 3'd2,
        MODE_MERGE = 3'd3,
        MODE_CLR_O = 3'd4,
        MODE_CLR_L = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OCC_AFTER  = 2'd0,
        OCC_BEFORE = 2'd1,
        OCC_CONC   = 2'd2,
        OCC_EQUAL  = 2'd3
    } occ_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IFETCH,
        S_ICHK,
        S_SFETCH,
        S_SWRITE,
        S_LFETCH,
        S_LCHK,
        S_CFETCH,
        S_CSTEP,
        S_CRESULT,
        S_MFETCH,
        S_MCOUNT,
        S_EFETCH,
        S_EMIT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    walk_clr;
        logic    rd_walk;
        logic    rd_shift;
        logic    rd_olast;
        logic    inc_a;
        logic    walk_step;
        logic    tail_flags;
        logic    cnt_write;
        logic    j_load;
        logic    shift_write;
        logic    ins_write;
        logic    load_write;
        logic    set_status;
        status_t status_val;
        logic    save_ntot;
        logic    merge_emit;
        logic    merge_done;
        logic    lsize_clr;
        logic    osize_clr;
        logic    out_result;
        logic    out_occ;
    } cmd_t;

    typedef struct packed {
        logic a_in;
        logic b_in;
        logic lk_lt_in;
        logic lk_eq_in;
        logic lc_max;
        logic lfull;
        logic ofull;
        logic onz;
        logic in_gt_ok;
        logic j_gt_a;
        logic n_gt_max;
        logic n_zero;
        logic n_last;
        logic out_free;
    } sts_t;

endpackage

>>> hdl/sparse_vector_clock_engine.sv
// Increment walks the local table to the key's place, then bumps the count on a
//   hit or shifts the later entries up and inserts; load checks the last other
//   entry; compare walks both tables; merge counts the merged entries, then emits
//   them, or one word if none or too many. One item at a time: the next item is
//   taken after the last result of the current one enters the output register.
// Reset: sizes, bank select, flags and output valid clear; tables get no clearing pass.
module sparse_vector_clock_engine #(
    parameter int MAX_ENTRIES = svce_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = svce_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS  = svce_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key [31:0], count [63:32]
    input  logic [svce_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode [2:0]
    input  logic [svce_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // occurrence [1:0], entry_key [33:2], entry_count [65:34], zeros [71:66]
    output logic [svce_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // entry_valid [0], status [2:1]
    output logic [svce_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    output logic                             m_axis_tlast
);
    import svce_pkg::*;

    cmd_t                  cmd;
    sts_t                  sts;
    logic [1:0]            occurrence;
    logic [KEY_PORT_W-1:0] entry_key;
    logic [CNT_PORT_W-1:0] entry_count;
    logic                  entry_valid;
    logic [1:0]            status;

    // Sequencer: walks the tables, each step a read state followed by an act state
    svce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .mode     (s_axis_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Tables, walk indexes, flags and the result register
    svce_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .key_in      (s_axis_tdata[KEY_PORT_W-1:0]),
        .count_in    (s_axis_tdata[KEY_PORT_W +: CNT_PORT_W]),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .occurrence  (occurrence),
        .entry_key   (entry_key),
        .entry_count (entry_count),
        .entry_valid (entry_valid),
        .last        (m_axis_tlast),
        .status      (status)
    );

    // Pack the result word, zero fill to whole bytes
    assign m_axis_tdata = {
        (M_TDATA_W - 2 - KEY_PORT_W - CNT_PORT_W)'(0),
        entry_count, entry_key, occurrence};
    assign m_axis_tuser = {status, entry_valid};

endmodule

>>> hdl/svce_ctrl.sv
module svce_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [svce_pkg::MODE_W-1:0]    mode,
    input  svce_pkg::sts_t                 sts,
    output svce_pkg::cmd_t                 cmd
);
    import svce_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (mode_t'(mode))
                        MODE_INC:
                        begin
                            cmd.walk_clr = 1'b1;
                            state_next   = S_IFETCH;
                        end
                        MODE_LOAD:
                        begin
                            state_next = S_LFETCH;
                        end
                        MODE_CMP:
                        begin
                            cmd.walk_clr = 1'b1;
                            state_next   = S_CFETCH;
                        end
                        MODE_MERGE:
                        begin
                            cmd.walk_clr = 1'b1;
                            state_next   = S_MFETCH;
                        end
                        MODE_CLR_O:
                        begin
                            cmd.osize_clr = 1'b1;
                            state_next    = S_RESULT;
                        end
                        MODE_CLR_L:
                        begin
                            cmd.lsize_clr = 1'b1;
                            state_next    = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_IFETCH:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = S_ICHK;
            end
            S_ICHK:
            begin
                if (sts.a_in && sts.lk_lt_in)
                begin
                    cmd.inc_a  = 1'b1;
                    state_next = S_IFETCH;
                end
                else if (sts.a_in && sts.lk_eq_in)
                begin
                    if (sts.lc_max)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = ST_SAT;
                    end
                    else
                    begin
                        cmd.cnt_write = 1'b1;
                    end
                    state_next = S_RESULT;
                end
                else if (sts.lfull)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_FULL;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.j_load = 1'b1;
                    state_next = S_SFETCH;
                end
            end
            S_SFETCH:
            begin
                if (sts.j_gt_a)
                begin
                    cmd.rd_shift = 1'b1;
                    state_next   = S_SWRITE;
                end
                else
                begin
                    cmd.ins_write = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_SWRITE:
            begin
                cmd.shift_write = 1'b1;
                state_next      = S_SFETCH;
            end
            S_LFETCH:
            begin
                cmd.rd_olast = 1'b1;
                state_next   = S_LCHK;
            end
            S_LCHK:
            begin
                if (sts.ofull)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_FULL;
                end
                else if (sts.onz && !sts.in_gt_ok)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_ORDER;
                end
                else
                begin
                    cmd.load_write = 1'b1;
                end
                state_next = S_RESULT;
            end
            S_CFETCH:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = S_CSTEP;
            end
            S_CSTEP:
            begin
                if (sts.a_in && sts.b_in)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_CFETCH;
                end
                else
                begin
                    cmd.tail_flags = 1'b1;
                    state_next     = S_CRESULT;
                end
            end
            S_CRESULT:
            begin
                // Flags are settled here: hand the order out with the word
                if (sts.out_free)
                begin
                    cmd.out_result = 1'b1;
                    cmd.out_occ    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MFETCH:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = S_MCOUNT;
            end
            S_MCOUNT:
            begin
                if (sts.a_in || sts.b_in)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_MFETCH;
                end
                else if (sts.n_gt_max)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_FULL;
                    state_next     = S_RESULT;
                end
                else if (sts.n_zero)
                begin
                    cmd.lsize_clr = 1'b1;
                    state_next    = S_RESULT;
                end
                else
                begin
                    cmd.save_ntot = 1'b1;
                    cmd.walk_clr  = 1'b1;
                    state_next    = S_EFETCH;
                end
            end
            S_EFETCH:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.merge_emit = 1'b1;
                    cmd.walk_step  = 1'b1;
                    if (sts.n_last)
                    begin
                        cmd.merge_done = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EFETCH;
                    end
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_result = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/svce_datapath.sv
module svce_datapath #(
    parameter int MAX_ENTRIES = svce_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = svce_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS  = svce_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  svce_pkg::cmd_t                    cmd,
    output svce_pkg::sts_t                    sts,
    input  logic [svce_pkg::KEY_PORT_W-1:0]   key_in,
    input  logic [svce_pkg::CNT_PORT_W-1:0]   count_in,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [1:0]                        occurrence,
    output logic [svce_pkg::KEY_PORT_W-1:0]   entry_key,
    output logic [svce_pkg::CNT_PORT_W-1:0]   entry_count,
    output logic                              entry_valid,
    output logic                              last,
    output logic [1:0]                        status
);
    import svce_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SW = $clog2(MAX_ENTRIES + 1);
    localparam int NW = $clog2(2 * MAX_ENTRIES + 1);
    localparam int EW = KEY_BITS + COUNT_BITS;

    // Two local banks: merge builds into the idle bank, then flips
    logic [EW-1:0] lmem [2][MAX_ENTRIES];
    logic [EW-1:0] omem [MAX_ENTRIES];

    logic [EW-1:0]         lrd_reg;
    logic [EW-1:0]         ord_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [COUNT_BITS-1:0] cnt_reg;

    logic [SW-1:0] lsize_reg, lsize_next;
    logic [SW-1:0] osize_reg, osize_next;
    logic [SW-1:0] a_reg, a_next;
    logic [SW-1:0] b_reg, b_next;
    logic [SW-1:0] j_reg, j_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] ntot_reg, ntot_next;
    logic          bank_reg, bank_next;
    logic          lbig_reg, lbig_next;
    logic          obig_reg, obig_next;
    status_t       status_reg, status_next;
    logic          out_valid_reg, out_valid_next;

    logic [1:0]            occ_reg;
    logic [KEY_PORT_W-1:0] okey_reg;
    logic [CNT_PORT_W-1:0] ocnt_reg;
    logic                  oev_reg;
    logic                  olast_reg;
    logic [1:0]            ost_reg;

    logic [KEY_BITS-1:0]   lk, ok, mkey;
    logic [COUNT_BITS-1:0] lc, oc, mcnt;
    logic                  a_in, b_in, lk_lt_ok, lk_eq_ok, take_a, take_b;
    logic [SW-1:0]         jm1, om1;
    logic                  l_we, l_wbank;
    logic [IW-1:0]         l_widx, l_ridx, o_ridx;
    logic [EW-1:0]         l_wdata;
    occ_t                  occ_calc;
    logic                  out_load;

    assign lk = lrd_reg[KEY_BITS-1:0];
    assign lc = lrd_reg[EW-1:KEY_BITS];
    assign ok = ord_reg[KEY_BITS-1:0];
    assign oc = ord_reg[EW-1:KEY_BITS];

    assign a_in     = (a_reg < lsize_reg);
    assign b_in     = (b_reg < osize_reg);
    assign lk_lt_ok = (lk < ok);
    assign lk_eq_ok = (lk == ok);
    assign take_a   = a_in && (!b_in || lk_lt_ok || lk_eq_ok);
    assign take_b   = b_in && (!a_in || !lk_lt_ok);
    assign jm1      = j_reg - 1'b1;
    assign om1      = osize_reg - 1'b1;

    assign mkey = take_a ? lk : ok;
    always_comb
    begin
        if (take_a && take_b)
        begin
            mcnt = (lc > oc) ? lc : oc;
        end
        else if (take_a)
        begin
            mcnt = lc;
        end
        else
        begin
            mcnt = oc;
        end
    end

    always_comb
    begin
        if (!lbig_reg && !obig_reg)
        begin
            occ_calc = OCC_EQUAL;
        end
        else if (!lbig_reg)
        begin
            occ_calc = OCC_BEFORE;
        end
        else if (!obig_reg)
        begin
            occ_calc = OCC_AFTER;
        end
        else
        begin
            occ_calc = OCC_CONC;
        end
    end

    assign sts.a_in     = a_in;
    assign sts.b_in     = b_in;
    assign sts.lk_lt_in = (lk < key_reg);
    assign sts.lk_eq_in = (lk == key_reg);
    assign sts.lc_max   = (lc == {COUNT_BITS{1'b1}});
    assign sts.lfull    = (lsize_reg == SW'(MAX_ENTRIES));
    assign sts.ofull    = (osize_reg == SW'(MAX_ENTRIES));
    assign sts.onz      = (osize_reg != '0);
    assign sts.in_gt_ok = (key_reg > ok);
    assign sts.j_gt_a   = (j_reg > a_reg);
    assign sts.n_gt_max = (n_reg > NW'(MAX_ENTRIES));
    assign sts.n_zero   = (n_reg == '0);
    assign sts.n_last   = (NW'(n_reg + 1'b1) == ntot_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    // Local bank write port
    always_comb
    begin
        l_we    = 1'b0;
        l_wbank = bank_reg;
        l_widx  = a_reg[IW-1:0];
        l_wdata = lrd_reg;
        if (cmd.cnt_write)
        begin
            l_we    = 1'b1;
            l_wdata = {COUNT_BITS'(lc + 1'b1), lk};
        end
        else if (cmd.ins_write)
        begin
            l_we    = 1'b1;
            l_wdata = {COUNT_BITS'(1), key_reg};
        end
        else if (cmd.shift_write)
        begin
            l_we   = 1'b1;
            l_widx = j_reg[IW-1:0];
        end
        else if (cmd.merge_emit)
        begin
            l_we    = 1'b1;
            l_wbank = !bank_reg;
            l_widx  = n_reg[IW-1:0];
            l_wdata = {mcnt, mkey};
        end
    end

    assign l_ridx = cmd.rd_shift ? jm1[IW-1:0] : a_reg[IW-1:0];
    assign o_ridx = cmd.rd_olast ? om1[IW-1:0] : b_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            lmem[l_wbank][l_widx] <= l_wdata;
        end
        if (cmd.rd_walk || cmd.rd_shift)
        begin
            lrd_reg <= lmem[bank_reg][l_ridx];
        end
        if (cmd.load_write)
        begin
            omem[osize_reg[IW-1:0]] <= {cnt_reg, key_reg};
        end
        if (cmd.rd_walk || cmd.rd_olast)
        begin
            ord_reg <= omem[o_ridx];
        end
    end

    // Control state
    always_comb
    begin
        lsize_next  = lsize_reg;
        osize_next  = osize_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        ntot_next   = ntot_reg;
        bank_next   = bank_reg;
        lbig_next   = lbig_reg;
        obig_next   = obig_reg;
        status_next = status_reg;

        if (cmd.capture)
        begin
            status_next = ST_OK;
        end
        if (cmd.set_status)
        begin
            status_next = cmd.status_val;
        end
        if (cmd.save_ntot)
        begin
            ntot_next = n_reg;
        end
        if (cmd.walk_clr)
        begin
            a_next    = '0;
            b_next    = '0;
            n_next    = '0;
            lbig_next = 1'b0;
            obig_next = 1'b0;
        end
        if (cmd.inc_a)
        begin
            a_next = a_reg + 1'b1;
        end
        if (cmd.walk_step)
        begin
            if (take_a)
            begin
                a_next = a_reg + 1'b1;
            end
            if (take_b)
            begin
                b_next = b_reg + 1'b1;
            end
            n_next = n_reg + 1'b1;
            if (a_in && b_in)
            begin
                if (lk_eq_ok)
                begin
                    if (lc > oc)
                    begin
                        lbig_next = 1'b1;
                    end
                    else if (lc < oc)
                    begin
                        obig_next = 1'b1;
                    end
                end
                else if (lk_lt_ok)
                begin
                    lbig_next = 1'b1;
                end
                else
                begin
                    obig_next = 1'b1;
                end
            end
        end
        if (cmd.tail_flags)
        begin
            if (a_in)
            begin
                lbig_next = 1'b1;
            end
            else if (b_in)
            begin
                obig_next = 1'b1;
            end
        end
        if (cmd.j_load)
        begin
            j_next = lsize_reg;
        end
        if (cmd.shift_write)
        begin
            j_next = jm1;
        end
        if (cmd.ins_write)
        begin
            lsize_next = lsize_reg + 1'b1;
        end
        if (cmd.load_write)
        begin
            osize_next = osize_reg + 1'b1;
        end
        if (cmd.merge_done)
        begin
            bank_next  = !bank_reg;
            lsize_next = SW'(ntot_reg);
        end
        if (cmd.lsize_clr)
        begin
            lsize_next = '0;
        end
        if (cmd.osize_clr)
        begin
            osize_next = '0;
        end
    end

    assign out_load = cmd.out_result || cmd.merge_emit;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsize_reg     <= '0;
            osize_reg     <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            ntot_reg      <= '0;
            bank_reg      <= 1'b0;
            lbig_reg      <= 1'b0;
            obig_reg      <= 1'b0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lsize_reg     <= lsize_next;
            osize_reg     <= osize_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            ntot_reg      <= ntot_next;
            bank_reg      <= bank_next;
            lbig_reg      <= lbig_next;
            obig_reg      <= obig_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word and result word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= KEY_BITS'(key_in);
            cnt_reg <= COUNT_BITS'(count_in);
        end
        if (cmd.merge_emit)
        begin
            occ_reg   <= OCC_AFTER;
            okey_reg  <= KEY_PORT_W'(mkey);
            ocnt_reg  <= CNT_PORT_W'(mcnt);
            oev_reg   <= 1'b1;
            olast_reg <= sts.n_last;
            ost_reg   <= ST_OK;
        end
        else if (cmd.out_result)
        begin
            occ_reg   <= cmd.out_occ ? occ_calc : OCC_AFTER;
            okey_reg  <= '0;
            ocnt_reg  <= '0;
            oev_reg   <= 1'b0;
            olast_reg <= 1'b1;
            ost_reg   <= status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign occurrence  = occ_reg;
    assign entry_key   = okey_reg;
    assign entry_count = ocnt_reg;
    assign entry_valid = oev_reg;
    assign last        = olast_reg;
    assign status      = ost_reg;

    a_lsize_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lsize_reg <= SW'(MAX_ENTRIES))
        else $error("local size beyond table depth");

    a_osize_bound: assert property (@(posedge clk) disable iff (!rst_n)
        osize_reg <= SW'(MAX_ENTRIES))
        else $error("other size beyond table depth");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_write |-> (lsize_reg < SW'(MAX_ENTRIES)))
        else $error("insert into full local table");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_emit |-> (n_reg < NW'(MAX_ENTRIES)) && (ntot_reg <= NW'(MAX_ENTRIES)))
        else $error("merge emit beyond table depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !out_load)
        else $error("result word overwritten while stalled");

endmodule

>>> test/sparse_vector_clock_engine_tb.sv
module sparse_vector_clock_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import svce_pkg::*;

    localparam int N_ENT     = 16;
    localparam int LIMIT_CYC = 400000;

    // One word as it leaves the block
    typedef struct packed {
        logic [1:0]  occ;
        logic [31:0] ekey;
        logic [31:0] ecnt;
        logic        evalid;
        logic        elast;
        logic [1:0]  status;
    } clk_word_t;

    // One directed row: fixed = 1 means the expected word is typed in
    typedef struct {
        logic [2:0]  mode;
        logic [31:0] key;
        logic [31:0] cnt;
        bit          fixed;
        clk_word_t   want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic m_axis_tlast;

    // Predictor copy of both clocks
    logic [31:0] loc_key [N_ENT];
    logic [31:0] loc_cnt [N_ENT];
    int          loc_n;
    logic [31:0] oth_key [N_ENT];
    logic [31:0] oth_cnt [N_ENT];
    int          oth_n;

    clk_word_t pending_words[$];
    int        err_count;
    int        cyc;
    bit        calm;        // no idling in the last part
    bit        hold_rx;     // long receiver stall
    int        hold_left;

    sparse_vector_clock_engine DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Append one expected word behind the others
    function automatic void queue_word(clk_word_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic clk_word_t single_word(logic [1:0] occ, logic [1:0] st);
        clk_word_t w;
        w = '0;
        w.occ = occ;
        w.elast = 1'b1;
        w.status = st;
        return w;
    endfunction

    // Bump or insert a key in the local clock
    function automatic logic [1:0] bump_local(logic [31:0] k);
        int i;
        i = 0;
        while (i < loc_n && loc_key[i] < k) i++;
        if (i < loc_n && loc_key[i] == k) begin
            if (loc_cnt[i] == '1) return ST_SAT;
            loc_cnt[i] = loc_cnt[i] + 32'd1;
            return ST_OK;
        end
        if (loc_n >= N_ENT) return ST_FULL;
        for (int j = loc_n; j > i; j--) begin
            loc_key[j] = loc_key[j-1];
            loc_cnt[j] = loc_cnt[j-1];
        end
        loc_key[i] = k;
        loc_cnt[i] = 32'd1;
        loc_n++;
        return ST_OK;
    endfunction

    function automatic logic [1:0] append_other(logic [31:0] k, logic [31:0] c);
        if (oth_n >= N_ENT) return ST_FULL;
        if (oth_n > 0 && k <= oth_key[oth_n-1]) return ST_ORDER;
        oth_key[oth_n] = k;
        oth_cnt[oth_n] = c;
        oth_n++;
        return ST_OK;
    endfunction

    function automatic logic [1:0] order_clocks();
        bit lb, ob;
        int a, b;
        lb = 0; ob = 0; a = 0; b = 0;
        while (a < loc_n && b < oth_n) begin
            if (loc_key[a] == oth_key[b]) begin
                if (loc_cnt[a] > oth_cnt[b]) lb = 1;
                else if (loc_cnt[a] < oth_cnt[b]) ob = 1;
                a++; b++;
            end else if (loc_key[a] > oth_key[b]) begin
                ob = 1; b++;
            end else begin
                lb = 1; a++;
            end
        end
        if (a < loc_n) lb = 1;
        else if (b < oth_n) ob = 1;
        if (!lb && !ob) return OCC_EQUAL;
        if (!lb) return OCC_BEFORE;
        if (!ob) return OCC_AFTER;
        return OCC_CONC;
    endfunction

    // Merge both clocks into the local one and queue the entries; empty or overflow queues one word
    task automatic merge_clocks();
        logic [31:0] mk [2*N_ENT];
        logic [31:0] mc [2*N_ENT];
        int a, b, n;
        clk_word_t w;
        a = 0; b = 0; n = 0;
        while (a < loc_n || b < oth_n) begin
            if (a < loc_n && b < oth_n && loc_key[a] == oth_key[b]) begin
                mk[n] = loc_key[a];
                mc[n] = (loc_cnt[a] > oth_cnt[b]) ? loc_cnt[a] : oth_cnt[b];
                a++; b++;
            end else if (b >= oth_n || (a < loc_n && loc_key[a] < oth_key[b])) begin
                mk[n] = loc_key[a]; mc[n] = loc_cnt[a]; a++;
            end else begin
                mk[n] = oth_key[b]; mc[n] = oth_cnt[b]; b++;
            end
            n++;
        end
        if (n > N_ENT) begin
            queue_word(single_word(OCC_AFTER, ST_FULL));
            return;
        end
        loc_n = n;
        if (n == 0) begin
            queue_word(single_word(OCC_AFTER, ST_OK));
            return;
        end
        for (int i = 0; i < n; i++) begin
            loc_key[i] = mk[i];
            loc_cnt[i] = mc[i];
            w = '0;
            w.ekey = mk[i];
            w.ecnt = mc[i];
            w.evalid = 1'b1;
            w.elast = (i == n - 1);
            queue_word(w);
        end
    endtask

    task automatic predict_words(logic [2:0] m, logic [31:0] k, logic [31:0] c);
        case (m)
            MODE_INC:   queue_word(single_word(OCC_AFTER, bump_local(k)));
            MODE_LOAD:  queue_word(single_word(OCC_AFTER, append_other(k, c)));
            MODE_CMP:   queue_word(single_word(order_clocks(), ST_OK));
            MODE_MERGE: merge_clocks();
            MODE_CLR_O: begin oth_n = 0; queue_word(single_word(OCC_AFTER, ST_OK)); end
            MODE_CLR_L: begin loc_n = 0; queue_word(single_word(OCC_AFTER, ST_OK)); end
            default:    queue_word(single_word(OCC_AFTER, ST_OK));
        endcase
    endtask

    task automatic report_mismatch(string what, logic [71:0] got, logic [71:0] want);
        $display("ERROR @%0t: %s got %0h want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Drive one word and wait for its handshake; valid stays up until the
    // next call drops it for a gap or replaces the word
    task automatic send_word(logic [2:0] m, logic [31:0] k, logic [31:0] c);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m;
        s_axis_tdata  <= {c, k};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_words(m, k, c);
        @(negedge clk);
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Receiver ready: random bursts of stall, or a long hold-off
    always @(negedge clk) begin
        if (!rst_n) m_axis_tready <= 1'b0;
        else if (hold_rx) begin
            m_axis_tready <= 1'b0;
            if (hold_left > 0) hold_left <= hold_left - 1;
            else hold_rx <= 1'b0;
        end else if (calm) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // Check each output word against the oldest expectation
    always @(posedge clk) begin
        clk_word_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.occ    = m_axis_tdata[1:0];
            got.ekey   = m_axis_tdata[33:2];
            got.ecnt   = m_axis_tdata[65:34];
            got.evalid = m_axis_tuser[0];
            got.status = m_axis_tuser[2:1];
            got.elast  = m_axis_tlast;
            if (pending_words.size() == 0) report_mismatch("unexpected word", 72'(got), '0);
            else begin
                want = pending_words.pop_front();
                if (got.occ != want.occ)
                    report_mismatch("occurrence", 72'(got.occ), 72'(want.occ));
                if (got.ekey != want.ekey)
                    report_mismatch("entry_key", 72'(got.ekey), 72'(want.ekey));
                if (got.ecnt != want.ecnt)
                    report_mismatch("entry_count", 72'(got.ecnt), 72'(want.ecnt));
                if (got.evalid != want.evalid)
                    report_mismatch("entry_valid", 72'(got.evalid), 72'(want.evalid));
                if (got.elast != want.elast)
                    report_mismatch("last", 72'(got.elast), 72'(want.elast));
                if (got.status != want.status)
                    report_mismatch("status", 72'(got.status), 72'(want.status));
                if (m_axis_tdata[71:66] != '0)
                    report_mismatch("tdata pad", 72'(m_axis_tdata[71:66]), '0);
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYC) begin
            $display("sparse_vector_clock_engine: mismatch");
            $finish;
        end
    end

    function automatic row_t mk_row(logic [2:0] m, logic [31:0] k, logic [31:0] c,
                                    bit fx, clk_word_t w);
        row_t r;
        r.mode = m; r.key = k; r.cnt = c; r.fixed = fx; r.want = w;
        return r;
    endfunction

    // Random key, half the time from two small pools, so keys collide often
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40);
            1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        row_t dir[$];
        int   nrand;
        logic [31:0] k, c;
        clk_word_t w0;
        err_count = 0; cyc = 0; calm = 0; hold_rx = 0; hold_left = 0;
        loc_n = 0; oth_n = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        w0 = '0;
        // Empty clocks: equal, empty merge
        dir = {dir, mk_row(MODE_CMP, 0, 0, 1, single_word(OCC_EQUAL, ST_OK))};
        dir = {dir, mk_row(MODE_MERGE, 0, 0, 1, single_word(OCC_AFTER, ST_OK))};
        dir = {dir, mk_row(MODE_INC, 32'hFFFF_FFFF, 0, 1, single_word(OCC_AFTER, ST_OK))};
        dir = {dir, mk_row(MODE_INC, 0, 0, 0, w0)};
        dir = {dir, mk_row(MODE_CMP, 0, 0, 1, single_word(OCC_AFTER, ST_OK))};
        dir = {dir, mk_row(MODE_LOAD, 0, 32'hFFFF_FFFF, 1, single_word(OCC_AFTER, ST_OK))};
        // Out-of-order load: equal key
        dir = {dir, mk_row(MODE_LOAD, 0, 5, 1, single_word(OCC_AFTER, ST_ORDER))};
        dir = {dir, mk_row(MODE_LOAD, 32'h8000_0000, 7, 0, w0)};
        dir = {dir, mk_row(MODE_CMP, 0, 0, 0, w0)};
        dir = {dir, mk_row(MODE_MERGE, 0, 0, 0, w0)};
        // Local now holds a count at all ones for key 0: saturation
        dir = {dir, mk_row(MODE_INC, 0, 0, 1, single_word(OCC_AFTER, ST_SAT))};
        dir = {dir, mk_row(MODE_CMP, 0, 0, 0, w0)};
        dir = {dir, mk_row(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                           single_word(OCC_AFTER, ST_OK))};
        dir = {dir, mk_row(3'd7, 0, 0, 1, single_word(OCC_AFTER, ST_OK))};
        dir = {dir, mk_row(MODE_CLR_O, 0, 0, 1, single_word(OCC_AFTER, ST_OK))};
        dir = {dir, mk_row(MODE_CMP, 0, 0, 1, single_word(OCC_AFTER, ST_OK))};
        dir = {dir, mk_row(MODE_CLR_L, 0, 0, 1, single_word(OCC_AFTER, ST_OK))};
        dir = {dir, mk_row(MODE_LOAD, 3, 1, 0, w0)};
        dir = {dir, mk_row(MODE_CMP, 0, 0, 1, single_word(OCC_BEFORE, ST_OK))};

        foreach (dir[i]) begin
            send_word(dir[i].mode, dir[i].key, dir[i].cnt);
            // Replace the predictor's word with the typed-in one
            if (dir[i].fixed) pending_words[pending_words.size() - 1] = dir[i].want;
        end

        // Fill the local table past its size: last insert reports full
        for (int i = 0; i < N_ENT + 1; i++) send_word(MODE_INC, 32'(100 + 2 * i), 0);
        // Fill other past its size with keys interleaving local
        for (int i = 0; i < N_ENT + 1; i++) send_word(MODE_LOAD, 32'(101 + 2 * i), $urandom);
        send_word(MODE_MERGE, 0, 0);   // overflows
        drain_wait();

        // Long receiver hold-off while the sender keeps offering words
        hold_left = 300;
        hold_rx = 1;
        send_word(MODE_CLR_O, 0, 0);
        for (int i = 0; i < 6; i++) send_word(MODE_LOAD, 32'(200 + i), 32'(i));
        send_word(MODE_MERGE, 0, 0);
        drain_wait();

        // Random part: well-formed sequences of increments, sorted loads,
        // then compare or merge; some noise in between
        nrand = 0;
        while (nrand < 220) begin
            if (nrand > 170) calm = 1;
            case ($urandom_range(0, 9))
                0: begin send_word(MODE_CLR_L, $urandom, $urandom); nrand++; end
                1: begin send_word(MODE_CLR_O, $urandom, $urandom); nrand++; end
                2: begin
                    send_word(3'($urandom_range(0, 7)), pick_key(), $urandom);
                    nrand++;
                end
                3, 4: begin
                    for (int i = $urandom_range(1, 6); i > 0; i--) begin
                        send_word(MODE_INC, pick_key(), $urandom);
                        nrand++;
                    end
                end
                default: begin
                    send_word(MODE_CLR_O, 0, 0);
                    k = $urandom_range(0, 20);
                    for (int i = $urandom_range(0, 8); i > 0; i--) begin
                        c = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 6);
                        send_word(MODE_LOAD, k, c);
                        k = k + $urandom_range(1, 8);
                        nrand++;
                    end
                    send_word(MODE_CMP, 0, 0);
                    send_word($urandom_range(0, 1) ? MODE_MERGE : MODE_CMP, 0, 0);
                    nrand += 3;
                end
            endcase
            if (nrand > 140 && nrand < 150) begin
                drain_wait();   // sender pauses until all results are in
                nrand += 10;
            end
        end

        drain_wait();
        repeat (100) @(negedge clk);
        if (err_count == 0) $display("sparse_vector_clock_engine: match");
        else $display("sparse_vector_clock_engine: mismatch");
        $finish;
    end
endmodule
